### rtl/erkf_pkg.sv
package erkf_pkg;

   localparam int ERKF_FRAC_BITS = 16;
   localparam int ERKF_DATA_W    = 32;
   localparam int ERKF_CSR_IDX_W = 3;

   // width*10/58 converts an echo time in microseconds to millimetres
   localparam int ERKF_MM_SCALE  = 10;
   localparam int ERKF_US_PER_CM = 58;
   localparam int ERKF_WIDTH_W   = 16;
   localparam int ERKF_W10_W     = 20;

   // floor(w/58) as (w*RECIP) >> SHIFT, exact for every w below 2^20
   localparam int ERKF_RECIP_58  = 1157050;
   localparam int ERKF_RECIP_SH  = 26;
   localparam int ERKF_CM_Q_W    = 14;

   localparam logic [15:0] ERKF_NOISE_LIMIT_RST = 16'd4000;
   localparam logic [31:0] ERKF_OBS_GAIN_RST    = 32'd65536;
   localparam logic [31:0] ERKF_MEAS_VAR_RST    = 32'd65536;
   localparam logic [31:0] ERKF_PROC_VAR_RST    = 32'd655;
   localparam logic [31:0] ERKF_INIT_ERR_RST    = 32'd65536;

   localparam logic [ERKF_CSR_IDX_W-1:0] CSR_NOISE_LIMIT = 3'd0;
   localparam logic [ERKF_CSR_IDX_W-1:0] CSR_OBS_GAIN    = 3'd1;
   localparam logic [ERKF_CSR_IDX_W-1:0] CSR_MEAS_VAR    = 3'd2;
   localparam logic [ERKF_CSR_IDX_W-1:0] CSR_PROC_VAR    = 3'd3;
   localparam logic [ERKF_CSR_IDX_W-1:0] CSR_INIT_ERR    = 3'd4;

   localparam logic [3:0] OP_NONE        = 4'd0;
   localparam logic [3:0] OP_LOAD        = 4'd1;
   localparam logic [3:0] OP_DIV_DIST    = 4'd2;
   localparam logic [3:0] OP_TAKE_Z      = 4'd3;
   localparam logic [3:0] OP_TAKE_NUM    = 4'd4;
   localparam logic [3:0] OP_TAKE_DEN    = 4'd5;
   localparam logic [3:0] OP_TAKE_HX     = 4'd6;
   localparam logic [3:0] OP_DIV_GAIN    = 4'd7;
   localparam logic [3:0] OP_TAKE_GAIN   = 4'd8;
   localparam logic [3:0] OP_TAKE_EST    = 4'd9;
   localparam logic [3:0] OP_TAKE_FACTOR = 4'd10;
   localparam logic [3:0] OP_TAKE_P      = 4'd11;
   localparam logic [3:0] OP_PUBLISH     = 4'd12;

   localparam logic [2:0] MUL_P_H        = 3'd0;
   localparam logic [2:0] MUL_NUM_H      = 3'd1;
   localparam logic [2:0] MUL_H_EST      = 3'd2;
   localparam logic [2:0] MUL_GAIN_INNOV = 3'd3;
   localparam logic [2:0] MUL_GAIN_H     = 3'd4;
   localparam logic [2:0] MUL_FACTOR_P   = 3'd5;

   typedef struct packed {
      logic [3:0] op;
      logic [2:0] mul_sel;
   } erkf_cmd_type;

   typedef struct packed {
      logic div_done;
      logic rsp_free;
   } erkf_status_type;

endpackage

### rtl/erkf_div.sv
module erkf_div #(
   parameter int DIV_W = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [31:0]      divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_W);

   logic [DIV_W-1:0] quo_ff;
   logic [31:0]      rem_ff;
   logic [31:0]      den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [32:0] rem_sh;
   logic [32:0] rem_diff;
   logic        fits;

   // one quotient bit a cycle, restoring
   assign rem_sh   = {rem_ff, quo_ff[DIV_W-1]};
   assign rem_diff = rem_sh - {1'b0, den_ff};
   assign fits     = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
         rem_ff <= fits ? rem_diff[31:0] : rem_sh[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(busy_ff))
      else $error("divider done without a run");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

endmodule

### rtl/erkf_dp.sv
module erkf_dp import erkf_pkg::*; #(
   parameter int FRAC_BITS = ERKF_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  erkf_cmd_type              cmd,
   output erkf_status_type           status,
   input  logic [ERKF_WIDTH_W-1:0]   req_echo_width_us,
   input  logic                      csr_wr_en,
   input  logic [ERKF_CSR_IDX_W-1:0] csr_index,
   input  logic [ERKF_DATA_W-1:0]    csr_wdata,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [15:0]               rsp_filtered_mm,
   output logic [13:0]               rsp_raw_mm,
   output logic                      rsp_was_clamped
);

   localparam int DIV_W = 32 + FRAC_BITS;
   localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;
   localparam int CM_TAB_N = ERKF_US_PER_CM;
   localparam int CM_REM_W = $clog2(ERKF_US_PER_CM);

   typedef logic [CM_TAB_N-1:0][31:0] cm_tab_type;

   // fraction part of r*2^FRAC_BITS/58 for each remainder r
   function automatic cm_tab_type build_cm_tab();
      cm_tab_type tab;
      for (int i = 0; i < CM_TAB_N; i++)
         tab[i] = 32'((64'(i) << FRAC_BITS) / 64'(ERKF_US_PER_CM));
      return tab;
   endfunction

   localparam cm_tab_type CM_TAB = build_cm_tab();

   function automatic logic [31:0] fx_sat(input logic [63:0] p);
      logic [63:0] s;
      s = p >> FRAC_BITS;
      return (|s[63:32]) ? '1 : s[31:0];
   endfunction

   function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? '1 : s[31:0];
   endfunction

   // configuration
   logic [15:0] noise_limit_ff;
   logic [31:0] obs_gain_ff, meas_var_ff, proc_var_ff;

   // filter state and working values
   logic [ERKF_WIDTH_W-1:0] width_ff;
   logic [31:0] last_ff, est_ff, p_ff;
   logic [31:0] z_ff, num_ff, denom_ff, hx_ff, gain_ff, factor_ff;
   logic        clamped_ff;
   logic [63:0] prod_ff;
   logic        rsp_valid_ff;
   logic [15:0] filtered_ff;
   logic [13:0] raw_ff;
   logic        was_clamped_ff;
   logic [ERKF_CM_Q_W-1:0] cm_q_ff;

   logic [31:0]      mul_a, mul_b;
   logic [31:0]      prod_fx;
   logic [31:0]      innov_mag;
   logic [ERKF_W10_W-1:0] w10;
   logic [ERKF_CM_Q_W-1:0] cm_q_in;
   logic [ERKF_W10_W-1:0]  cm_q_x58;
   logic [CM_REM_W-1:0]    cm_rem;
   logic [DIV_W-1:0] dist_fx;
   logic [31:0]      dist_sat;
   logic             div_start, div_done;
   logic [DIV_W-1:0] div_dividend, div_quotient, limit_w;
   logic [31:0]      div_divisor, quo_sat;
   logic [63:0]      delta;
   logic [64:0]      est_up;
   logic [31:0]      est_in, z_in, gain_in, factor_in;
   logic             clamped_in;
   logic [31:0]      fint;
   logic [31:0]      zint;

   assign w10 = ERKF_W10_W'(width_ff) * ERKF_W10_W'(ERKF_MM_SCALE);

   // distance: integer quotient by reciprocal multiplication, fraction from the remainder
   assign cm_q_in  = ERKF_CM_Q_W'((48'(w10) * 48'(ERKF_RECIP_58)) >> ERKF_RECIP_SH);
   assign cm_q_x58 = ERKF_W10_W'(cm_q_ff) * ERKF_W10_W'(ERKF_US_PER_CM);
   assign cm_rem   = CM_REM_W'(w10 - cm_q_x58);
   assign dist_fx  = (DIV_W'(cm_q_ff) << FRAC_BITS) + DIV_W'(CM_TAB[cm_rem]);
   assign dist_sat = (|dist_fx[DIV_W-1:32]) ? '1 : dist_fx[31:0];

   assign div_start    = (cmd.op == OP_DIV_GAIN);
   assign div_dividend = DIV_W'(num_ff) << FRAC_BITS;
   assign div_divisor  = denom_ff;

   erkf_div #(.DIV_W(DIV_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign quo_sat    = (|div_quotient[DIV_W-1:32]) ? '1 : div_quotient[31:0];
   assign limit_w    = DIV_W'(noise_limit_ff) << FRAC_BITS;
   assign clamped_in = dist_fx > limit_w;
   assign z_in       = clamped_in ? last_ff : dist_sat;

   assign innov_mag  = (z_ff >= hx_ff) ? (z_ff - hx_ff) : (hx_ff - z_ff);

   always_comb begin
      unique case (cmd.mul_sel)
         MUL_P_H:        begin mul_a = p_ff;      mul_b = obs_gain_ff; end
         MUL_NUM_H:      begin mul_a = num_ff;    mul_b = obs_gain_ff; end
         MUL_H_EST:      begin mul_a = obs_gain_ff; mul_b = est_ff;    end
         MUL_GAIN_INNOV: begin mul_a = gain_ff;   mul_b = innov_mag;   end
         MUL_GAIN_H:     begin mul_a = gain_ff;   mul_b = obs_gain_ff; end
         MUL_FACTOR_P:   begin mul_a = factor_ff; mul_b = p_ff;        end
         default:        begin mul_a = p_ff;      mul_b = obs_gain_ff; end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= {32'b0, mul_a} * {32'b0, mul_b};
   end

   assign prod_fx = fx_sat(prod_ff);

   // innovation step: magnitude product, then add or subtract with saturation
   assign delta  = prod_ff >> FRAC_BITS;
   assign est_up = {33'b0, est_ff} + {1'b0, delta};
   always_comb begin
      if (z_ff >= hx_ff)
         est_in = (|est_up[64:32]) ? '1 : est_up[31:0];
      else
         est_in = (delta >= {32'b0, est_ff}) ? '0 : est_ff - delta[31:0];
   end

   always_comb begin
      if (denom_ff == '0)
         gain_in = (num_ff == '0) ? '0 : '1;
      else
         gain_in = quo_sat;
   end

   assign factor_in = (prod_fx >= ONE) ? '0 : ONE - prod_fx;

   assign fint = est_ff >> FRAC_BITS;
   assign zint = z_ff >> FRAC_BITS;

   // working registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD:        width_ff  <= req_echo_width_us;
         OP_DIV_DIST:    cm_q_ff   <= cm_q_in;
         OP_TAKE_Z: begin
            z_ff       <= z_in;
            clamped_ff <= clamped_in;
         end
         OP_TAKE_NUM:    num_ff    <= prod_fx;
         OP_TAKE_DEN:    denom_ff  <= add_sat(prod_fx, meas_var_ff);
         OP_TAKE_HX:     hx_ff     <= prod_fx;
         OP_TAKE_GAIN:   gain_ff   <= gain_in;
         OP_TAKE_FACTOR: factor_ff <= factor_in;
         OP_PUBLISH: begin
            filtered_ff    <= (|fint[31:16]) ? 16'hFFFF : fint[15:0];
            raw_ff         <= zint[13:0];
            was_clamped_ff <= clamped_ff;
         end
         default: ;
      endcase
   end

   // filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         est_ff  <= '0;
         p_ff    <= ERKF_INIT_ERR_RST;
      end else begin
         if (cmd.op == OP_TAKE_Z)   last_ff <= z_in;
         if (cmd.op == OP_TAKE_EST) est_ff  <= est_in;
         if (cmd.op == OP_TAKE_P)   p_ff    <= add_sat(prod_fx, proc_var_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_limit_ff <= ERKF_NOISE_LIMIT_RST;
         obs_gain_ff    <= ERKF_OBS_GAIN_RST;
         meas_var_ff    <= ERKF_MEAS_VAR_RST;
         proc_var_ff    <= ERKF_PROC_VAR_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NOISE_LIMIT: noise_limit_ff <= csr_wdata[15:0];
            CSR_OBS_GAIN:    obs_gain_ff    <= csr_wdata;
            CSR_MEAS_VAR:    meas_var_ff    <= csr_wdata;
            CSR_PROC_VAR:    proc_var_ff    <= csr_wdata;
            // initial_error seeds p only at reset, where its default applies
            CSR_INIT_ERR:    ;
            default: ;
         endcase
      end
   end

   // hold the word until taken; a new word may replace it on the same edge
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.op == OP_PUBLISH)
         rsp_valid_ff <= 1'b1;
      else if (rsp_ready)
         rsp_valid_ff <= 1'b0;
   end

   assign status.div_done = div_done;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_filtered_mm = filtered_ff;
   assign rsp_raw_mm      = raw_ff;
   assign rsp_was_clamped = was_clamped_ff;

endmodule

### rtl/erkf_ctrl.sv
module erkf_ctrl import erkf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  erkf_status_type status,
   output erkf_cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_DIST_GO   = 4'd1;
   localparam logic [3:0] ST_DIST_WAIT = 4'd2;
   localparam logic [3:0] ST_NUM_MUL   = 4'd3;
   localparam logic [3:0] ST_NUM_TAKE  = 4'd4;
   localparam logic [3:0] ST_DEN_MUL   = 4'd5;
   localparam logic [3:0] ST_DEN_TAKE  = 4'd6;
   localparam logic [3:0] ST_HX_TAKE   = 4'd7;
   localparam logic [3:0] ST_GAIN_GO   = 4'd8;
   localparam logic [3:0] ST_GAIN_WAIT = 4'd9;
   localparam logic [3:0] ST_DELTA_MUL = 4'd10;
   localparam logic [3:0] ST_EST_TAKE  = 4'd11;
   localparam logic [3:0] ST_KH_TAKE   = 4'd12;
   localparam logic [3:0] ST_P_MUL     = 4'd13;
   localparam logic [3:0] ST_P_TAKE    = 4'd14;
   localparam logic [3:0] ST_DONE      = 4'd15;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.op      = OP_NONE;
      cmd.mul_sel = MUL_P_H;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_DIST_GO;
            end
         end
         ST_DIST_GO: begin
            cmd.op   = OP_DIV_DIST;
            state_in = ST_DIST_WAIT;
         end
         ST_DIST_WAIT: begin
            cmd.op   = OP_TAKE_Z;
            state_in = ST_NUM_MUL;
         end
         ST_NUM_MUL: begin
            cmd.mul_sel = MUL_P_H;
            state_in    = ST_NUM_TAKE;
         end
         ST_NUM_TAKE: begin
            cmd.op   = OP_TAKE_NUM;
            state_in = ST_DEN_MUL;
         end
         ST_DEN_MUL: begin
            cmd.mul_sel = MUL_NUM_H;
            state_in    = ST_DEN_TAKE;
         end
         ST_DEN_TAKE: begin
            cmd.op      = OP_TAKE_DEN;
            cmd.mul_sel = MUL_H_EST;
            state_in    = ST_HX_TAKE;
         end
         ST_HX_TAKE: begin
            cmd.op   = OP_TAKE_HX;
            state_in = ST_GAIN_GO;
         end
         ST_GAIN_GO: begin
            cmd.op   = OP_DIV_GAIN;
            state_in = ST_GAIN_WAIT;
         end
         ST_GAIN_WAIT: begin
            if (status.div_done) begin
               cmd.op   = OP_TAKE_GAIN;
               state_in = ST_DELTA_MUL;
            end
         end
         ST_DELTA_MUL: begin
            cmd.mul_sel = MUL_GAIN_INNOV;
            state_in    = ST_EST_TAKE;
         end
         ST_EST_TAKE: begin
            cmd.op      = OP_TAKE_EST;
            cmd.mul_sel = MUL_GAIN_H;
            state_in    = ST_KH_TAKE;
         end
         ST_KH_TAKE: begin
            cmd.op   = OP_TAKE_FACTOR;
            state_in = ST_P_MUL;
         end
         ST_P_MUL: begin
            cmd.mul_sel = MUL_FACTOR_P;
            state_in    = ST_P_TAKE;
         end
         ST_P_TAKE: begin
            cmd.op   = OP_TAKE_P;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (status.rsp_free) begin
               cmd.op   = OP_PUBLISH;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

### rtl/echo_range_kalman_filter.sv
// The controller takes one word at a time: a new word is accepted only in the idle state,
// after the previous one has passed the bit-serial gain divider and been published;
// publishing stalls while the previous result is untaken.
// A finished result waits in the output register while the next word is taken in.
// Reset (synchronous, active high) loads register defaults, clears the estimate and the
// previous reading, and sets the error covariance to the initial_error default.
module echo_range_kalman_filter import erkf_pkg::*; #(
   parameter int FRAC_BITS = ERKF_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [ERKF_WIDTH_W-1:0]   req_echo_width_us,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [15:0]               rsp_filtered_mm,
   output logic [13:0]               rsp_raw_mm,
   output logic                      rsp_was_clamped,
   input  logic                      csr_wr_en,
   input  logic [ERKF_CSR_IDX_W-1:0] csr_index,
   input  logic [ERKF_DATA_W-1:0]    csr_wdata
);

   erkf_cmd_type    cmd;
   erkf_status_type status;

   erkf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   erkf_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_echo_width_us (req_echo_width_us),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_filtered_mm   (rsp_filtered_mm),
      .rsp_raw_mm        (rsp_raw_mm),
      .rsp_was_clamped   (rsp_was_clamped)
   );

endmodule

### tb/erkf_range_monitor.sv
`timescale 1ns / 1ps

module erkf_range_monitor import erkf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [ERKF_WIDTH_W-1:0]   req_echo_width_us,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [15:0]               rsp_filtered_mm,
   input  logic [13:0]               rsp_raw_mm,
   input  logic                      rsp_was_clamped,
   input  logic                      csr_wr_en,
   input  logic [ERKF_CSR_IDX_W-1:0] csr_index,
   input  logic [ERKF_DATA_W-1:0]    csr_wdata,
   output int                        fails,
   output int                        outstanding
);

   localparam int          FB     = ERKF_FRAC_BITS;
   localparam logic [63:0] MAX32  = 64'h0000_0000_FFFF_FFFF;
   localparam logic [31:0] ONE_FX = 32'd1 << FB;

   typedef struct packed {
      logic [15:0] filtered_mm;
      logic [13:0] raw_mm;
      logic        was_clamped;
   } range_sample_type;

   logic [15:0]      limit_mm;
   logic [31:0]      h_fx, r_fx, q_fx;
   logic [31:0]      prev_z_fx, est_fx, cov_fx;
   range_sample_type range_due_q[$];

   function automatic logic [31:0] sat32(input logic [63:0] v);
      return (v > MAX32) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   function automatic logic [31:0] fx_mul(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] prod;
      prod = 64'(a) * 64'(b);
      return sat32(prod >> FB);
   endfunction

   // One filter update: convert, clamp against the noise limit, then the Kalman step.
   task automatic kalman_advance(input logic [15:0] width, output range_sample_type res);
      logic [63:0] range_fx, limit, quot, delta;
      logic [31:0] z, num, denom, gain, hx, kh, factor, fint, zint;
      logic        clamped;
      range_fx = ((64'(width) * 64'(ERKF_MM_SCALE)) << FB) / 64'(ERKF_US_PER_CM);
      limit    = 64'(limit_mm) << FB;
      clamped  = range_fx > limit;
      z        = clamped ? prev_z_fx : sat32(range_fx);
      prev_z_fx = z;

      num   = fx_mul(cov_fx, h_fx);
      denom = sat32(64'(fx_mul(fx_mul(h_fx, cov_fx), h_fx)) + 64'(r_fx));
      if (denom == '0) begin
         gain = (num == '0) ? 32'h0 : 32'hFFFF_FFFF;
      end else begin
         quot = (64'(num) << FB) / 64'(denom);
         gain = sat32(quot);
      end

      // negative innovation works on the magnitude and floors the estimate at zero
      hx = fx_mul(h_fx, est_fx);
      if (z >= hx) begin
         delta  = (64'(gain) * 64'(z - hx)) >> FB;
         est_fx = sat32(64'(est_fx) + delta);
      end else begin
         delta  = (64'(gain) * 64'(hx - z)) >> FB;
         est_fx = (delta >= 64'(est_fx)) ? 32'h0 : est_fx - delta[31:0];
      end

      kh     = fx_mul(gain, h_fx);
      factor = (kh >= ONE_FX) ? 32'h0 : ONE_FX - kh;
      cov_fx = sat32(64'(fx_mul(factor, cov_fx)) + 64'(q_fx));

      fint = est_fx >> FB;
      zint = z >> FB;
      res.filtered_mm = (fint > 32'h0000_FFFF) ? 16'hFFFF : fint[15:0];
      res.raw_mm      = zint[13:0];
      res.was_clamped = clamped;
   endtask

   always @(posedge clock) begin : watch
      range_sample_type due;
      if (reset) begin
         limit_mm  = ERKF_NOISE_LIMIT_RST;
         h_fx      = ERKF_OBS_GAIN_RST;
         r_fx      = ERKF_MEAS_VAR_RST;
         q_fx      = ERKF_PROC_VAR_RST;
         prev_z_fx = '0;
         est_fx    = '0;
         cov_fx    = ERKF_INIT_ERR_RST;
         range_due_q.delete();
      end else begin
         // initial_error only reaches p through a reset, so ignore it here
         if (csr_wr_en) begin
            case (csr_index)
               CSR_NOISE_LIMIT: limit_mm = csr_wdata[15:0];
               CSR_OBS_GAIN:    h_fx     = csr_wdata;
               CSR_MEAS_VAR:    r_fx     = csr_wdata;
               CSR_PROC_VAR:    q_fx     = csr_wdata;
               CSR_INIT_ERR:    ;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            kalman_advance(req_echo_width_us, due);
            range_due_q.push_back(due);
         end
         if (rsp_valid && rsp_ready) begin
            if (range_due_q.size() == 0) begin
               $error("result word with nothing pending: filtered_mm %0d raw_mm %0d was_clamped %0d",
                      rsp_filtered_mm, rsp_raw_mm, rsp_was_clamped);
               fails++;
            end else begin
               due = range_due_q.pop_front();
               if (rsp_filtered_mm !== due.filtered_mm) begin
                  $error("filtered_mm expected %0d, got %0d", due.filtered_mm, rsp_filtered_mm);
                  fails++;
               end
               if (rsp_raw_mm !== due.raw_mm) begin
                  $error("raw_mm expected %0d, got %0d", due.raw_mm, rsp_raw_mm);
                  fails++;
               end
               if (rsp_was_clamped !== due.was_clamped) begin
                  $error("was_clamped expected %0d, got %0d", due.was_clamped, rsp_was_clamped);
                  fails++;
               end
            end
         end
      end
      outstanding <= range_due_q.size();
   end

endmodule

### tb/tb_echo_range_kalman_filter.sv
`timescale 1ns / 1ps

module tb_echo_range_kalman_filter;
   import erkf_pkg::*;

   localparam int RUN_LIMIT       = 1000000;
   localparam int HOLD_OFF_CYCLES = 1500;
   localparam int SETTLE_CYCLES   = 150;

   logic                      clock             = 1'b0;
   logic                      reset             = 1'b1;
   logic                      req_valid         = 1'b0;
   logic                      req_ready;
   logic [ERKF_WIDTH_W-1:0]   req_echo_width_us = '0;
   logic                      rsp_valid;
   logic                      rsp_ready         = 1'b0;
   logic [15:0]               rsp_filtered_mm;
   logic [13:0]               rsp_raw_mm;
   logic                      rsp_was_clamped;
   logic                      csr_wr_en         = 1'b0;
   logic [ERKF_CSR_IDX_W-1:0] csr_index         = CSR_NOISE_LIMIT;
   logic [ERKF_DATA_W-1:0]    csr_wdata         = '0;

   int   fails;
   int   outstanding;
   int   req_idle_pct = 0;
   int   rsp_idle_pct = 0;
   logic hold_rsp     = 1'b0;
   int   words_sent   = 0;
   int   cycle_count  = 0;
   int   walk_us      = 8000;

   logic [15:0] directed_us[$] = '{16'd0, 16'hFFFF, 16'd23200, 16'd23201, 16'd5800, 16'd1,
                                   16'd57, 16'd58, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA,
                                   16'd11600, 16'd0, 16'd23200};

   echo_range_kalman_filter DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_echo_width_us (req_echo_width_us),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_filtered_mm   (rsp_filtered_mm),
      .rsp_raw_mm        (rsp_raw_mm),
      .rsp_was_clamped   (rsp_was_clamped),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   erkf_range_monitor MON (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_echo_width_us (req_echo_width_us),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_filtered_mm   (rsp_filtered_mm),
      .rsp_raw_mm        (rsp_raw_mm),
      .rsp_was_clamped   (rsp_was_clamped),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fails             (fails),
      .outstanding       (outstanding)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= !hold_rsp && ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("FAIL echo_range_kalman_filter");
         $finish;
      end
   end

   // Hold off results for a long stretch so the block fills up and stalls its input.
   initial begin
      wait (words_sent == 40);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   function automatic logic [15:0] pick_echo(input logic [15:0] limit_mm);
      int sel, stride, knee_us;
      sel = $urandom_range(99);
      if (sel < 45) begin
         // slowly moving target with the odd spike
         stride  = $urandom_range(400);
         walk_us = walk_us + stride - 200;
         if (walk_us < 0) walk_us = 0;
         else if (walk_us > 65535) walk_us = 65535;
         if ($urandom_range(15) == 0) return 16'($urandom_range(65535, 30000));
         return 16'(walk_us);
      end
      if (sel < 65) begin
         // hover around the width that lands exactly on the noise limit
         knee_us = int'(limit_mm) * ERKF_US_PER_CM / ERKF_MM_SCALE
                   + int'($urandom_range(8)) - 4;
         if (knee_us < 0) knee_us = 0;
         else if (knee_us > 65535) knee_us = 65535;
         return 16'(knee_us);
      end
      if (sel < 85) return 16'($urandom);
      case ($urandom_range(3))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h5555;
         default: return 16'hAAAA;
      endcase
   endfunction

   task automatic send_echo(input logic [15:0] width);
      int gap;
      gap = 0;
      if (req_idle_pct != 0 && $urandom_range(7) == 0) begin
         gap = $urandom_range(160, 1);
      end else begin
         while ($urandom_range(99) < req_idle_pct) gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_echo_width_us <= width;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic feed_random(input int words, input logic [15:0] limit_mm);
      repeat (words) send_echo(pick_echo(limit_mm));
   endtask

   // Drop valid and wait until every pending result word has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_csr(input logic [ERKF_CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_filter(input logic [31:0] noise, input logic [31:0] h,
                             input logic [31:0] r, input logic [31:0] q,
                             input logic [31:0] p0);
      write_csr(CSR_NOISE_LIMIT, noise);
      write_csr(CSR_OBS_GAIN, h);
      write_csr(CSR_MEAS_VAR, r);
      write_csr(CSR_PROC_VAR, q);
      write_csr(CSR_INIT_ERR, p0);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_idle(input int req_pct, input int rsp_pct);
      req_idle_pct = req_pct;
      rsp_idle_pct <= rsp_pct;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      set_idle(31, 79);
      set_filter(32'd4000, 32'd65536, 32'd65536, 32'd655, 32'd65536);
      foreach (directed_us[i]) send_echo(directed_us[i]);
      feed_random(80, 16'd4000);
      drain();

      // zero limit clamps everything but a zero width; r of zero drives gain*h to one and, with q of zero, p to zero
      set_filter(32'd0, 32'd65536, 32'd0, 32'd0, 32'd0);
      feed_random(60, 16'd0);
      drain();

      // tiny h with r of zero leaves a zero denominator and a saturated gain
      set_filter(32'd65535, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      feed_random(60, 16'd65535);
      drain();

      set_idle(79, 31);
      set_filter(32'd1234, 32'd0, 32'd0, 32'd0, 32'd1);
      feed_random(50, 16'd1234);
      drain();

      set_filter(32'd8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678);
      feed_random(60, 16'd8000);
      drain();

      // junk in the upper half of the limit word must be dropped
      set_filter({16'($urandom), 16'd3000}, $urandom, $urandom,
                 $urandom_range(32'h0003_FFFF), $urandom);
      feed_random(80, 16'd3000);
      drain();

      set_idle(0, 0);
      set_filter(32'd5000, 32'h0001_8000, 32'h0000_8000, 32'h0000_0100, 32'd0);
      feed_random(70, 16'd5000);
      drain();

      set_filter(32'd4000, 32'd65536, 32'd65536, 32'd655, 32'd65536);
      feed_random(90, 16'd4000);
      drain();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fails == 0) begin
         $display("PASS echo_range_kalman_filter");
      end else begin
         $display("FAIL echo_range_kalman_filter");
      end
      $finish;
   end

endmodule
